/* hdl/base64url_codec_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the base64url codec
// Shared property wrappers, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64URL_CODEC_UNIT_DEFINES_SVH
`define BASE64URL_CODEC_UNIT_DEFINES_SVH

// same-cycle implication
`define B64U_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64u: same-cycle check failed");

// next-cycle implication
`define B64U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64u: next-cycle check failed");

`endif

/* hdl/b64u_pkg.sv */
// ----------------------------------------------------------------------------
// b64u_pkg
// Types, codes and alphabet functions for the base64url codec.
// ----------------------------------------------------------------------------
package b64u_pkg;

    localparam int unsigned MaxResults = 3;

    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_END_OK     = 3'd1;
    localparam logic [2:0] KIND_INVALID    = 3'd2;
    localparam logic [2:0] KIND_NONCANON   = 3'd3;
    localparam logic [2:0] KIND_BAD_LENGTH = 3'd4;

    localparam logic [1:0] FAIL_NONE    = 2'd0;
    localparam logic [1:0] FAIL_INVALID = 2'd1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // register byte offsets
    localparam logic [2:0] REG_DIRECTION = 3'd0;

    // alphabet anchors
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [5:0] VAL_LOWER  = 6'd26;
    localparam logic [5:0] VAL_DIGIT  = 6'd52;
    localparam logic [5:0] VAL_MINUS  = 6'd62;
    localparam logic [5:0] VAL_UNDER  = 6'd63;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_item;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       end_of_run;
    } t_out_item;

    typedef struct packed {
        logic [11:0] bit_accumulator;
        logic [3:0]  pending_bits;
        logic [1:0]  length_mod_four;
        logic [1:0]  failure_code;
    } t_stream_state;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  item2;
        t_out_item  item1;
        t_out_item  item0;
    } t_step_result;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_dec_char;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < VAL_LOWER) begin
            c = CH_UPPER_A + 8'(v);
        end else if (v < VAL_DIGIT) begin
            c = CH_LOWER_A + 8'(v - VAL_LOWER);
        end else if (v < VAL_MINUS) begin
            c = CH_DIGIT_0 + 8'(v - VAL_DIGIT);
        end else if (v == VAL_MINUS) begin
            c = CH_MINUS;
        end else begin
            c = CH_UNDER;
        end
        return c;
    endfunction

    function automatic t_dec_char dec_char(input logic [7:0] c);
        t_dec_char d;
        d = '0;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            d.valid = 1'b1;
            d.value = 6'(c - CH_UPPER_A);
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            d.valid = 1'b1;
            d.value = 6'(c - CH_LOWER_A) + VAL_LOWER;
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            d.valid = 1'b1;
            d.value = 6'(c - CH_DIGIT_0) + VAL_DIGIT;
        end else if (c == CH_MINUS) begin
            d.valid = 1'b1;
            d.value = VAL_MINUS;
        end else if (c == CH_UNDER) begin
            d.valid = 1'b1;
            d.value = VAL_UNDER;
        end
        return d;
    endfunction

endpackage

/* hdl/b64u_step.sv */
// ----------------------------------------------------------------------------
// b64u_step
// One item's worth of encode or decode: next stream state and up to three
// result items.
// ----------------------------------------------------------------------------
module b64u_step (
    input  logic                   i_direction,
    input  b64u_pkg::t_stream_state i_state,
    input  b64u_pkg::t_in_item     i_item,
    output b64u_pkg::t_stream_state o_next_state,
    output b64u_pkg::t_step_result o_result
);

    b64u_pkg::t_out_item  res [b64u_pkg::MaxResults];
    logic [1:0]           n;
    logic [4:0]           p;
    logic [11:0]          acc;
    logic [11:0]          mask;
    logic [1:0]           len_n;
    logic [1:0]           fail_n;
    logic [2:0]           kind_s;
    b64u_pkg::t_dec_char  d;

    always_comb begin
        for (int k = 0; k < b64u_pkg::MaxResults; k++) begin
            res[k] = '0;
        end
        n      = 2'd0;
        acc    = i_state.bit_accumulator;
        p      = {1'b0, i_state.pending_bits};
        len_n  = i_state.length_mod_four;
        fail_n = i_state.failure_code;
        mask   = '0;
        kind_s = b64u_pkg::KIND_END_OK;
        d      = b64u_pkg::dec_char(i_item.symbol);

        if (i_direction == b64u_pkg::DIR_ENCODE) begin
            acc = {i_state.bit_accumulator[3:0], i_item.symbol};
            p   = p + 5'd8;
            // at most two characters out of the new byte
            if (p >= 5'd6) begin
                p        = p - 5'd6;
                res[0]   = '{b64u_pkg::KIND_DATA, b64u_pkg::enc_char(6'(acc >> p)), 1'b0};
                n        = 2'd1;
            end
            if (p >= 5'd6) begin
                p        = p - 5'd6;
                res[1]   = '{b64u_pkg::KIND_DATA, b64u_pkg::enc_char(6'(acc >> p)), 1'b0};
                n        = 2'd2;
            end
            if (i_item.final_item) begin
                // flush leftover bits, zero-filled on the right
                if (p != 5'd0 && p < 5'd6) begin
                    res[n] = '{b64u_pkg::KIND_DATA,
                               b64u_pkg::enc_char(6'(acc << (5'd6 - p))), 1'b0};
                    n      = n + 2'd1;
                end
                res[n] = '{b64u_pkg::KIND_END_OK, 8'd0, 1'b1};
                n      = n + 2'd1;
            end
        end else begin
            len_n = i_state.length_mod_four + 2'd1;
            if (!d.valid) begin
                fail_n = b64u_pkg::FAIL_INVALID;
            end else if (i_state.failure_code == b64u_pkg::FAIL_NONE) begin
                acc = {i_state.bit_accumulator[5:0], d.value};
                p   = p + 5'd6;
                if (p >= 5'd8) begin
                    p      = p - 5'd8;
                    res[0] = '{b64u_pkg::KIND_DATA, 8'(acc >> p), 1'b0};
                    n      = 2'd1;
                end
            end
            if (i_item.final_item) begin
                mask = (p >= 5'd12) ? 12'hFFF : ~(12'hFFF << p);
                if (len_n == 2'd1) begin
                    kind_s = b64u_pkg::KIND_BAD_LENGTH;
                end else if (fail_n != b64u_pkg::FAIL_NONE) begin
                    kind_s = b64u_pkg::KIND_INVALID;
                end else if ((acc & mask) != 12'd0) begin
                    kind_s = b64u_pkg::KIND_NONCANON;
                end else begin
                    kind_s = b64u_pkg::KIND_END_OK;
                end
                res[n] = '{kind_s, 8'd0, 1'b1};
                n      = n + 2'd1;
            end
        end

        if (i_item.final_item) begin
            o_next_state = '0;
        end else begin
            o_next_state.bit_accumulator = acc;
            o_next_state.pending_bits    = p[3:0];
            o_next_state.length_mod_four = len_n;
            o_next_state.failure_code    = fail_n;
        end

        o_result.count = n;
        o_result.item0 = res[0];
        o_result.item1 = res[1];
        o_result.item2 = res[2];
    end

endmodule

/* hdl/base64url_codec_unit.sv */
// An accepted item passes the input stage, then the result buffer. Throughput:
// one item per cycle at the input while the buffer drains in time; results
// leave one per cycle through the single result port while i_out_ready is
// high. An item waits until the last result of the one before it leaves.
// Reset (synchronous, active low) clears the direction to encode, the stream
// state, the input stage and the result buffer.
// ----------------------------------------------------------------------------
// base64url_codec_unit
// Unpadded base64url encoder/decoder with an APB direction register.
// ----------------------------------------------------------------------------
`include "base64url_codec_unit_defines.svh"

module base64url_codec_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b64u_pkg::t_in_item  i_in_item,
    // result item channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64u_pkg::t_out_item o_out_item,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // configuration
    logic                     r_direction;
    logic                     cfg_we;

    // stream state
    b64u_pkg::t_stream_state  r_state;
    b64u_pkg::t_stream_state  n_state;

    // input stage
    logic                     r_in_valid;
    b64u_pkg::t_in_item       r_in_item;

    // result buffer: up to three items per input item, drained from r_head
    b64u_pkg::t_out_item      r_buf [b64u_pkg::MaxResults];
    logic [1:0]               r_head;
    logic [1:0]               r_cnt;

    b64u_pkg::t_step_result   step_res;
    logic                     out_fire;
    logic                     buf_free;
    logic                     proc;

    // ---- APB ----
    // paddr[2] selects the register index; only index 0 exists
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == b64u_pkg::REG_DIRECTION[2]);
    assign prdata = (paddr[2] == b64u_pkg::REG_DIRECTION[2]) ? {31'd0, r_direction} : 32'd0;

    // ---- handshake ----
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_buf[r_head];
    assign out_fire    = o_out_valid && i_out_ready;
    // buffer can take a new batch when it is empty or its last item leaves now
    assign buf_free    = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_fire);
    assign proc        = r_in_valid && buf_free;
    assign o_in_ready  = !r_in_valid || proc;

    b64u_step u_step (
        .i_direction  (r_direction),
        .i_state      (r_state),
        .i_item       (r_in_item),
        .o_next_state (n_state),
        .o_result     (step_res)
    );

    // ---- control and state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= b64u_pkg::DIR_ENCODE;
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_head      <= 2'd0;
            r_cnt       <= 2'd0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            if (cfg_we) begin
                // a direction write abandons any open stream
                r_direction <= pwdata[0];
                r_state     <= '0;
            end else if (proc) begin
                r_state <= n_state;
            end

            if (proc) begin
                r_head <= 2'd0;
                r_cnt  <= step_res.count;
            end else if (out_fire) begin
                r_head <= r_head + 2'd1;
                r_cnt  <= r_cnt - 2'd1;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (proc) begin
            r_buf[0] <= step_res.item0;
            r_buf[1] <= step_res.item1;
            r_buf[2] <= step_res.item2;
        end
    end

    // ---- assertions ----
    // a status result is exactly the one that closes a stream
    `B64U_ASSERT_IMPL(a_status_is_end, i_clk, i_rst_n, o_out_valid, ((o_out_item.kind == b64u_pkg::KIND_DATA) == !o_out_item.end_of_run))
    // buffer reads never run past the last entry
    `B64U_ASSERT_IMPL(a_buf_bounds, i_clk, i_rst_n, o_out_valid, (({1'b0, r_head} + {1'b0, r_cnt}) <= 3'd3))
    // a held input stage keeps its item until the buffer frees up
    `B64U_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, (r_in_valid && !proc), (r_in_valid && $stable(r_in_item)))
    // a direction write leaves a clean stream
    `B64U_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, cfg_we, (r_state == '0))

endmodule
